// ===== design/assert_macros.svh =====
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define BDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next cycle
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bdq_pkg.sv =====
// package for the bounded deque: widths, operation and status codes
package bdq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int STAT_W       = 2;
    localparam int OCC_W        = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

// ===== design/bounded_deque_with_remove_by_value.sv =====
// top level of the bounded deque with remove by value
//
// Commands come in on the s_ channel: s_tuser carries the operation, s_tdata the
// value. Each command gives one result word on the m_ channel: m_tuser carries
// the status, m_tdata the popped or removed value and the occupancy after it.
// Entries sit in a circular buffer in one ram; head pointer and count live in
// flops, so pushes and pops touch one ram entry.
// Pushes, failed commands and unknown codes load their result straight into
// the output register; a pop goes through a ram read, a capture and then the
// output register. A removal scans from the front at one entry a cycle through
// the ram read port, then moves the entries behind the match one place forward
// at one a cycle, and hands its result to the output register when it is done.
// One command is in flight at a time; the next is taken once the result sits in
// the output register. The output register holds while m_tready is low, and
// no new command is taken until it can accept a result.
// Reset clears the count, head pointer and control state; the ram is not
// cleared, as only entries that were written are ever read.
module bounded_deque_with_remove_by_value #(
    parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]  s_tuser,   // [2:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] result_value, [36:32] occupancy, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    `include "assert_macros.svh"

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int DW  = bdq_pkg::DATA_W;
    localparam int SW  = bdq_pkg::STAT_W;
    localparam int OW  = bdq_pkg::OCC_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POP   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [DW-1:0] value_reg, value_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          rvalid_reg, rvalid_next;
    logic [AW-1:0] cmp_ptr_reg, cmp_ptr_next;
    logic [CW-1:0] cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] moves_reg, moves_next;
    logic [CW-1:0] rd_left_reg, rd_left_next;
    logic [DW-1:0] res_reg, res_next;
    logic [SW-1:0] stat_reg, stat_next;

    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] out_res_reg, out_res_next;
    logic [SW-1:0] out_stat_reg, out_stat_next;
    logic [OW-1:0] out_occ_reg, out_occ_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    logic          out_free;
    logic          accept;
    logic          is_full;
    logic          is_empty;
    logic          match;
    logic          load_out;
    logic [DW-1:0] load_res;
    logic [SW-1:0] load_stat;
    logic [CW-1:0] moves_left;

    logic          in_walk;
    logic          shift_ok;
    logic          push_ok;

    // circular pointer helpers
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(CAPACITY - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(CAPACITY - 1) : p - AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [CW-1:0] n);
        logic [AW:0] s;
        s = (AW+1)'(p) + (AW+1)'(n);
        if (s >= (AW+1)'(CAPACITY))
        begin
            s = s - (AW+1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    bdq_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign is_full  = (count_reg >= CW'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign match    = rvalid_reg && (ram_rdata == value_reg);
    assign moves_left = count_reg - CW'(1) - cmp_idx_reg;

    // sequencer and ram access
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        value_next   = value_reg;
        issue_next   = issue_reg;
        rd_ptr_next  = rd_ptr_reg;
        rvalid_next  = 1'b0;
        cmp_ptr_next = cmp_ptr_reg;
        cmp_idx_next = cmp_idx_reg;
        wr_ptr_next  = wr_ptr_reg;
        moves_next   = moves_reg;
        rd_left_next = rd_left_reg;
        res_next     = res_reg;
        stat_next    = stat_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;
        load_out     = 1'b0;
        load_res     = '0;
        load_stat    = bdq_pkg::STAT_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next = s_tdata;
                    case (s_tuser)
                        bdq_pkg::OP_PUSH_FRONT:
                        begin
                            load_out = 1'b1;
                            if (is_full)
                            begin
                                load_stat = bdq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = ptr_dec(head_reg);
                                ram_wdata  = s_tdata;
                                head_next  = ptr_dec(head_reg);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bdq_pkg::OP_PUSH_BACK:
                        begin
                            load_out = 1'b1;
                            if (is_full)
                            begin
                                load_stat = bdq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = ptr_add(head_reg, count_reg);
                                ram_wdata  = s_tdata;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bdq_pkg::OP_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                load_out  = 1'b1;
                                load_stat = bdq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ram_raddr  = head_reg;
                                head_next  = ptr_inc(head_reg);
                                count_next = count_reg - CW'(1);
                                state_next = S_POP;
                            end
                        end
                        bdq_pkg::OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                load_out  = 1'b1;
                                load_stat = bdq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ram_raddr  = ptr_add(head_reg, count_reg - CW'(1));
                                count_next = count_reg - CW'(1);
                                state_next = S_POP;
                            end
                        end
                        bdq_pkg::OP_REMOVE:
                        begin
                            if (is_empty)
                            begin
                                load_out  = 1'b1;
                                load_stat = bdq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                issue_next  = '0;
                                rd_ptr_next = head_reg;
                                state_next  = S_SCAN;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                res_next   = ram_rdata;
                stat_next  = bdq_pkg::STAT_OK;
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (match)
                begin
                    res_next  = value_reg;
                    stat_next = bdq_pkg::STAT_OK;
                    if (moves_left == '0)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        wr_ptr_next  = cmp_ptr_reg;
                        rd_ptr_next  = ptr_inc(cmp_ptr_reg);
                        moves_next   = moves_left;
                        rd_left_next = moves_left;
                        state_next   = S_SHIFT;
                    end
                end
                else if (rvalid_reg && (cmp_idx_reg == count_reg - CW'(1)))
                begin
                    res_next   = '0;
                    stat_next  = bdq_pkg::STAT_EMPTY;
                    state_next = S_DONE;
                end
                else if (issue_reg < count_reg)
                begin
                    // read the next entry from the front
                    ram_raddr    = rd_ptr_reg;
                    rd_ptr_next  = ptr_inc(rd_ptr_reg);
                    issue_next   = issue_reg + CW'(1);
                    rvalid_next  = 1'b1;
                    cmp_ptr_next = rd_ptr_reg;
                    cmp_idx_next = issue_reg;
                end
            end
            S_SHIFT:
            begin
                // read one entry ahead, write it one place toward the front
                if (rd_left_reg != '0)
                begin
                    ram_raddr    = rd_ptr_reg;
                    rd_ptr_next  = ptr_inc(rd_ptr_reg);
                    rd_left_next = rd_left_reg - CW'(1);
                    rvalid_next  = 1'b1;
                end
                if (rvalid_reg)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = wr_ptr_reg;
                    ram_wdata   = ram_rdata;
                    wr_ptr_next = ptr_inc(wr_ptr_reg);
                    moves_next  = moves_reg - CW'(1);
                    if (moves_reg == CW'(1))
                    begin
                        count_next  = count_reg - CW'(1);
                        rvalid_next = 1'b0;
                        state_next  = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    load_res   = res_reg;
                    load_stat  = stat_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_stat_next  = out_stat_reg;
        out_occ_next   = out_occ_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_res_next   = load_res;
            out_stat_next  = load_stat;
            out_occ_next   = OW'(count_next);
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rvalid_reg    <= rvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        issue_reg    <= issue_next;
        rd_ptr_reg   <= rd_ptr_next;
        cmp_ptr_reg  <= cmp_ptr_next;
        cmp_idx_reg  <= cmp_idx_next;
        wr_ptr_reg   <= wr_ptr_next;
        moves_reg    <= moves_next;
        rd_left_reg  <= rd_left_next;
        res_reg      <= res_next;
        stat_reg     <= stat_next;
        out_res_reg  <= out_res_next;
        out_stat_reg <= out_stat_next;
        out_occ_reg  <= out_occ_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(40 - DW - OW)'(0), out_occ_reg, out_res_reg};
    assign m_tuser  = out_stat_reg;

    // terms used by the checks
    assign in_walk  = (state_reg == S_SCAN) || (state_reg == S_SHIFT);
    assign shift_ok = (moves_reg != '0) && (rd_left_reg <= moves_reg);
    assign push_ok  = accept && !is_full
                      && ((s_tuser == bdq_pkg::OP_PUSH_FRONT) || (s_tuser == bdq_pkg::OP_PUSH_BACK));

    // checks
    `BDQ_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY), "entry count beyond capacity")
    `BDQ_ASSERT(a_rvalid_state, !rvalid_reg || in_walk, "read data pending outside scan or shift")
    `BDQ_ASSERT(a_shift_counts, state_reg != S_SHIFT || shift_ok, "shift counters out of step")
    `BDQ_ASSERT_NEXT(a_push_grows, push_ok, count_reg == $past(count_reg) + CW'(1), "push did not grow")

endmodule

// ===== design/bdq_ram.sv =====
// generic simple dual-port ram with registered read
module bdq_ram #(
    parameter int WIDTH = bdq_pkg::DATA_W,
    parameter int DEPTH = bdq_pkg::CAPACITY_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
